>>> src/owm_pkg.sv
`timescale 1ns / 1ps

package owm_pkg;

   // configuration register file
   localparam int CFG_W     = 10;
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = 3;

   // default slot timer width
   localparam int TIMER_BITS_DEF = 10;

   // fixed recovery time at the end of every bit slot
   localparam int REC_TICKS = 5;

   // register indexes
   localparam logic [REG_IDX_W-1:0] R_RESET_LOW  = 3'd0;
   localparam logic [REG_IDX_W-1:0] R_PRES_WAIT  = 3'd1;
   localparam logic [REG_IDX_W-1:0] R_RESET_TAIL = 3'd2;
   localparam logic [REG_IDX_W-1:0] R_ZERO_LOW   = 3'd3;
   localparam logic [REG_IDX_W-1:0] R_ONE_LOW    = 3'd4;
   localparam logic [REG_IDX_W-1:0] R_ONE_HIGH   = 3'd5;
   localparam logic [REG_IDX_W-1:0] R_READ_LOW   = 3'd6;
   localparam logic [REG_IDX_W-1:0] R_READ_TAIL  = 3'd7;

   typedef logic [CFG_W-1:0] cfg_word_type;
   typedef cfg_word_type [NUM_REGS-1:0] cfg_file_type;

   // register reset values, index 0 at the lowest slot
   localparam cfg_file_type CFG_RESET = '{
      cfg_word_type'(75),  cfg_word_type'(5),  cfg_word_type'(25), cfg_word_type'(5),
      cfg_word_type'(80),  cfg_word_type'(240), cfg_word_type'(100), cfg_word_type'(480)
   };

   // commands carried with each tick
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_RESET = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // bus phases
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_WAIT = 4'd2;
   localparam logic [3:0] PH_RST_TAIL = 4'd3;
   localparam logic [3:0] PH_W_LOW    = 4'd4;
   localparam logic [3:0] PH_W_HIGH   = 4'd5;
   localparam logic [3:0] PH_W_REC    = 4'd6;
   localparam logic [3:0] PH_R_LOW    = 4'd7;
   localparam logic [3:0] PH_R_SAMPLE = 4'd8;
   localparam logic [3:0] PH_R_TAIL   = 4'd9;
   localparam logic [3:0] PH_R_REC    = 4'd10;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

>>> src/one_wire_bus_master_top.sv
`timescale 1ns / 1ps
// the result beat of a tick is registered and valid in the cycle after the tick beat is taken
// throughput: one tick beat per cycle while the result side keeps taking beats
// a full output register parts the two sides; ready drops only while it holds a stalled beat
// reset (synchronous, active high) returns the bus to idle, clears shift, count and
// presence state and loads the default timing registers; no clearing pass is needed
module one_wire_bus_master_top
   import owm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // tick channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // tx_byte[7:0], line_level[8], zero fill
   input  logic [1:0]           req_tuser,   // action[1:0]
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                             // presence[3], rx_byte[11:4], refused[12]
   // configuration writes
   input  logic                 csr_we,
   input  logic [REG_IDX_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int WB = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
   localparam logic [WB-1:0] TMAX_W = WB'((1 << TIMER_BITS) - 1);
   localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);
   localparam logic [TIMER_BITS-1:0] T_REC = TIMER_BITS'(REC_TICKS);

   typedef logic [TIMER_BITS-1:0] timer_type;

   // saturate a register value into the timer range
   function automatic timer_type dur_raw(input cfg_word_type v);
      logic [WB-1:0] w;
      w = WB'(v);
      if (w > TMAX_W) begin
         return TMAX_W[TIMER_BITS-1:0];
      end
      return w[TIMER_BITS-1:0];
   endfunction

   // same, with zero read as one
   function automatic timer_type dur_min1(input cfg_word_type v);
      if (v == '0) begin
         return T_ONE;
      end
      return dur_raw(v);
   endfunction

   cfg_file_type    regs_ff;
   logic [3:0]      phase_ff, phase_in;
   timer_type       timer_ff, timer_in;
   logic [7:0]      shift_ff, shift_in;
   logic [3:0]      count_ff, count_in;
   logic            pres_ff, pres_in;
   logic [7:0]      rx_ff, rx_in;
   logic            rsp_valid_ff;
   logic [15:0]     rsp_data_ff, rsp_data_in;

   logic            accept;
   logic [1:0]      act;
   logic [7:0]      tx_byte;
   logic            line_level;
   logic            drive, busy, done, refused;

   assign act        = req_tuser;
   assign tx_byte    = req_tdata[7:0];
   assign line_level = req_tdata[8];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= CFG_RESET;
      end else if (csr_we) begin
         regs_ff[csr_addr] <= csr_wdata;
      end
   end

   // one tick: command start, phase output, timer step, phase change
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      pres_in  = pres_ff;
      rx_in    = rx_ff;
      drive    = 1'b0;
      busy     = 1'b0;
      done     = 1'b0;
      refused  = 1'b0;

      // command decode
      if (act != ACT_TICK && phase_ff != PH_IDLE) begin
         refused = 1'b1;
      end else if (act == ACT_RESET) begin
         phase_in = PH_RST_LOW;
         timer_in = dur_min1(regs_ff[R_RESET_LOW]);
      end else if (act == ACT_WRITE) begin
         shift_in = tx_byte;
         count_in = '0;
         phase_in = PH_W_LOW;
         timer_in = tx_byte[0] ? dur_min1(regs_ff[R_ONE_LOW])
                               : dur_min1(regs_ff[R_ZERO_LOW]);
      end else if (act == ACT_READ) begin
         shift_in = '0;
         count_in = '0;
         phase_in = PH_R_LOW;
         timer_in = dur_min1(regs_ff[R_READ_LOW]);
      end

      if (phase_in != PH_IDLE) begin
         busy  = 1'b1;
         drive = (phase_in == PH_RST_LOW) || (phase_in == PH_W_LOW) ||
                 (phase_in == PH_R_LOW);
         if (phase_in == PH_R_SAMPLE) begin
            shift_in = {line_level, shift_in[7:1]};
         end
         if (phase_in == PH_RST_WAIT && timer_in <= T_ONE) begin
            pres_in = !line_level;
         end
         if (timer_in != '0) begin
            timer_in = timer_in - T_ONE;
         end

         // slot timer expired: move to the next phase
         if (timer_in == '0) begin
            unique case (phase_in)
               PH_RST_LOW: begin
                  phase_in = PH_RST_WAIT;
                  timer_in = dur_min1(regs_ff[R_PRES_WAIT]);
               end
               PH_RST_WAIT: begin
                  phase_in = PH_RST_TAIL;
                  timer_in = dur_min1(regs_ff[R_RESET_TAIL]);
               end
               PH_W_LOW: begin
                  if (shift_in[0] && dur_raw(regs_ff[R_ONE_HIGH]) != '0) begin
                     phase_in = PH_W_HIGH;
                     timer_in = dur_raw(regs_ff[R_ONE_HIGH]);
                  end else begin
                     phase_in = PH_W_REC;
                     timer_in = T_REC;
                  end
               end
               PH_W_HIGH: begin
                  phase_in = PH_W_REC;
                  timer_in = T_REC;
               end
               PH_W_REC: begin
                  shift_in = {1'b0, shift_in[7:1]};
                  count_in = count_in + 4'd1;
                  if (count_in >= BITS_PER_BYTE) begin
                     phase_in = PH_IDLE;
                     timer_in = '0;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_W_LOW;
                     timer_in = shift_in[0] ? dur_min1(regs_ff[R_ONE_LOW])
                                            : dur_min1(regs_ff[R_ZERO_LOW]);
                  end
               end
               PH_R_LOW: begin
                  phase_in = PH_R_SAMPLE;
                  timer_in = T_ONE;
               end
               PH_R_SAMPLE: begin
                  if (dur_raw(regs_ff[R_READ_TAIL]) != '0) begin
                     phase_in = PH_R_TAIL;
                     timer_in = dur_raw(regs_ff[R_READ_TAIL]);
                  end else begin
                     phase_in = PH_R_REC;
                     timer_in = T_REC;
                  end
               end
               PH_R_TAIL: begin
                  phase_in = PH_R_REC;
                  timer_in = T_REC;
               end
               PH_R_REC: begin
                  count_in = count_in + 4'd1;
                  if (count_in >= BITS_PER_BYTE) begin
                     rx_in    = shift_in;
                     phase_in = PH_IDLE;
                     timer_in = '0;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_R_LOW;
                     timer_in = dur_min1(regs_ff[R_READ_LOW]);
                  end
               end
               default: begin
                  // reset tail end and unused codes
                  phase_in = PH_IDLE;
                  timer_in = '0;
                  done     = 1'b1;
               end
            endcase
         end
      end

      rsp_data_in = {3'b000, refused, rx_in, pres_in, done, busy, drive};
   end

   // bus state, advanced once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         shift_ff <= '0;
         count_ff <= '0;
         pres_ff  <= 1'b0;
         rx_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         pres_ff  <= pres_in;
         rx_ff    <= rx_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // checks
   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> timer_ff == '0)
      else $error("slot timer running while idle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BITS_PER_BYTE)
      else $error("bit count past one byte");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[0] || rsp_data_ff[2] || rsp_data_ff[12]) |->
      rsp_data_ff[1])
      else $error("drive, done or refused outside an operation");

   a_refused_busy: assert property (@(posedge clock) disable iff (reset)
      accept && act != ACT_TICK && phase_ff != PH_IDLE |=> phase_ff == $past(phase_in))
      else $error("refused command disturbed the phase");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(timer_ff))
      else $error("bus state moved without a tick beat");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import owm_pkg::*;

   // one result beat, drive_low in the lowest bit
   typedef struct packed {
      logic       refused;
      logic [7:0] rx_byte;
      logic       presence;
      logic       done;
      logic       busy;
      logic       drive_low;
   } bus_tick_type;

   localparam cfg_word_type DEFAULT_TIMING [NUM_REGS] = '{
      10'd480, 10'd100, 10'd240, 10'd80, 10'd5, 10'd25, 10'd5, 10'd75
   };

   // short slots so that whole operations fit in a few dozen ticks
   localparam cfg_word_type SHORT_TIMING [NUM_REGS] = '{
      10'd4, 10'd3, 10'd3, 10'd2, 10'd1, 10'd1, 10'd1, 10'd1
   };

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;   // tx_byte[7:0], line_level[8], zero fill
   logic [1:0]           req_tuser  = '0;   // action[1:0]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;         // drive_low[0], busy_res[1], done_res[2],
                                            // presence[3], rx_byte[11:4], refused[12]
   logic                 csr_we     = 1'b0;
   logic [REG_IDX_W-1:0] csr_addr   = '0;
   logic [CFG_W-1:0]     csr_wdata  = '0;

   // bus master mirror
   logic [3:0]   bus_phase;
   logic [9:0]   slot_cnt;
   logic [7:0]   shift_bits;
   logic [3:0]   bits_done;
   logic         saw_presence;
   logic [7:0]   last_rx;
   cfg_word_type timing [NUM_REGS];
   cfg_word_type next_timing [NUM_REGS];

   bus_tick_type bus_results_due [$];

   int  mismatches     = 0;
   int  ticks_sent     = 0;
   int  ops_finished   = 0;
   int  refusals_seen  = 0;
   bit  req_gaps_on    = 1'b1;
   bit  rsp_gaps_on    = 1'b1;
   int  stall_len      = 0;
   int  stall_req_id   = 0;
   int  stall_seen_id  = 0;
   int  stall_left     = 0;

   one_wire_bus_master_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // durations that need at least one tick
   function automatic logic [9:0] span_min1(input logic [REG_IDX_W-1:0] idx);
      return (timing[idx] == '0) ? 10'd1 : timing[idx];
   endfunction

   function automatic void start_write_bit();
      bus_phase = PH_W_LOW;
      slot_cnt  = shift_bits[0] ? span_min1(R_ONE_LOW) : span_min1(R_ZERO_LOW);
   endfunction

   function automatic void start_read_bit();
      bus_phase = PH_R_LOW;
      slot_cnt  = span_min1(R_READ_LOW);
   endfunction

   // move to the next phase when the slot timer runs out, 1 when the operation ends
   function automatic logic leave_phase();
      case (bus_phase)
         PH_RST_LOW: begin
            bus_phase = PH_RST_WAIT;
            slot_cnt  = span_min1(R_PRES_WAIT);
            return 1'b0;
         end
         PH_RST_WAIT: begin
            bus_phase = PH_RST_TAIL;
            slot_cnt  = span_min1(R_RESET_TAIL);
            return 1'b0;
         end
         PH_W_LOW: begin
            if (shift_bits[0] && timing[R_ONE_HIGH] != '0) begin
               bus_phase = PH_W_HIGH;
               slot_cnt  = timing[R_ONE_HIGH];
            end else begin
               bus_phase = PH_W_REC;
               slot_cnt  = 10'(REC_TICKS);
            end
            return 1'b0;
         end
         PH_W_HIGH: begin
            bus_phase = PH_W_REC;
            slot_cnt  = 10'(REC_TICKS);
            return 1'b0;
         end
         PH_W_REC: begin
            shift_bits = shift_bits >> 1;
            bits_done  = bits_done + 4'd1;
            if (bits_done < BITS_PER_BYTE) begin
               start_write_bit();
               return 1'b0;
            end
         end
         PH_R_LOW: begin
            bus_phase = PH_R_SAMPLE;
            slot_cnt  = 10'd1;
            return 1'b0;
         end
         PH_R_SAMPLE: begin
            if (timing[R_READ_TAIL] != '0) begin
               bus_phase = PH_R_TAIL;
               slot_cnt  = timing[R_READ_TAIL];
            end else begin
               bus_phase = PH_R_REC;
               slot_cnt  = 10'(REC_TICKS);
            end
            return 1'b0;
         end
         PH_R_TAIL: begin
            bus_phase = PH_R_REC;
            slot_cnt  = 10'(REC_TICKS);
            return 1'b0;
         end
         PH_R_REC: begin
            bits_done = bits_done + 4'd1;
            if (bits_done >= BITS_PER_BYTE) begin
               last_rx = shift_bits;
            end else begin
               start_read_bit();
               return 1'b0;
            end
         end
         default: ;
      endcase
      bus_phase = PH_IDLE;
      slot_cnt  = '0;
      return 1'b1;
   endfunction

   // expected result beat of one tick, advancing the mirror
   function automatic bus_tick_type predict_bus_tick(input logic [1:0] act,
                                                     input logic [7:0] txb,
                                                     input logic line);
      bus_tick_type r;
      r = '0;
      if (act != ACT_TICK && bus_phase != PH_IDLE) begin
         r.refused = 1'b1;
      end else if (act == ACT_RESET) begin
         bus_phase = PH_RST_LOW;
         slot_cnt  = span_min1(R_RESET_LOW);
      end else if (act == ACT_WRITE) begin
         shift_bits = txb;
         bits_done  = '0;
         start_write_bit();
      end else if (act == ACT_READ) begin
         shift_bits = '0;
         bits_done  = '0;
         start_read_bit();
      end
      if (bus_phase != PH_IDLE) begin
         r.busy      = 1'b1;
         r.drive_low = (bus_phase == PH_RST_LOW || bus_phase == PH_W_LOW ||
                        bus_phase == PH_R_LOW);
         if (bus_phase == PH_R_SAMPLE) shift_bits = {line, shift_bits[7:1]};
         if (bus_phase == PH_RST_WAIT && slot_cnt <= 10'd1) saw_presence = !line;
         if (slot_cnt > 0) slot_cnt = slot_cnt - 10'd1;
         if (slot_cnt == '0) r.done = leave_phase();
      end
      r.presence = saw_presence;
      r.rx_byte  = last_rx;
      return r;
   endfunction

   // true when the coming tick is the last one of the running operation
   function automatic logic op_ends_now();
      return slot_cnt == 10'd1 &&
             (bus_phase == PH_RST_TAIL ||
              ((bus_phase == PH_W_REC || bus_phase == PH_R_REC) &&
               bits_done == BITS_PER_BYTE - 4'd1));
   endfunction

   // result side ready, with random gaps and requested long stalls
   always @(negedge clock) begin
      if (stall_req_id != stall_seen_id) begin
         stall_seen_id = stall_req_id;
         stall_left    = stall_len;
      end
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = !(rsp_gaps_on && $urandom_range(99) < 28);
      end
   end

   task automatic check_field(input string label, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
      end
   endtask

   // compare every result beat with the oldest expectation
   always @(posedge clock) begin : result_check
      bus_tick_type got;
      bus_tick_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[12:0];
         if (bus_results_due.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with nothing expected, expected none actual %h",
                     $time, got);
         end else begin
            want = bus_results_due.pop_front();
            check_field("drive_low", want.drive_low, got.drive_low);
            check_field("busy", want.busy, got.busy);
            check_field("done", want.done, got.done);
            check_field("presence", want.presence, got.presence);
            check_field("rx_byte", want.rx_byte, got.rx_byte);
            check_field("refused", want.refused, got.refused);
            if (got.done) ops_finished++;
            if (got.refused) refusals_seen++;
         end
      end
   end

   // one tick beat, with random gaps before it
   task automatic send_tick(input logic [1:0] act, input logic [7:0] txb, input logic line);
      @(negedge clock);
      while (req_gaps_on && $urandom_range(99) < 28) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = {7'b0, line, txb};
      do @(posedge clock); while (req_tready !== 1'b1);
      bus_results_due.push_back(predict_bus_tick(act, txb, line));
      ticks_sent++;
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (bus_results_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // a command then ticks, with refused commands mixed in when asked, until the bus is idle
   // again; the emulated device answers with dev bit by bit, or the line is random when noisy
   task automatic run_op(input logic [1:0] act, input logic [7:0] txb, input logic [7:0] dev,
                         input bit noisy, input bit refuse_mid, input bit refuse_end);
      logic [1:0] cmd;
      logic       line;
      line = noisy ? 1'($urandom) : dev[bits_done[2:0]];
      send_tick(act, txb, line);
      while (bus_phase != PH_IDLE) begin
         cmd = ACT_TICK;
         if (refuse_end && op_ends_now())
            cmd = 2'($urandom_range(3, 1));
         else if (refuse_mid && $urandom_range(99) < 4)
            cmd = 2'($urandom_range(3, 1));
         line = noisy ? 1'($urandom) : dev[bits_done[2:0]];
         send_tick(cmd, 8'($urandom), line);
      end
   endtask

   // write every timing register from next_timing, bus idle and results drained
   task automatic load_timing();
      wait_all_results();
      for (int i = 0; i < NUM_REGS; i++) begin
         @(negedge clock);
         csr_we    = 1'b1;
         csr_addr  = REG_IDX_W'(i);
         csr_wdata = next_timing[i];
         timing[i] = next_timing[i];
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_all_timing(input cfg_word_type v);
      for (int i = 0; i < NUM_REGS; i++) next_timing[i] = v;
   endtask

   task automatic set_random_timing(input int hi);
      for (int i = 0; i < NUM_REGS; i++) next_timing[i] = cfg_word_type'($urandom_range(hi, 0));
   endtask

   // bus reset with and without a device answering, short timing
   task automatic test_presence_short();
      next_timing = SHORT_TIMING;
      load_timing();
      for (int i = 0; i < 4; i++) send_tick(ACT_TICK, 8'($urandom), 1'($urandom));
      run_op(ACT_RESET, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      run_op(ACT_RESET, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1);
   endtask

   // one byte write and one byte read, short timing
   task automatic test_byte_transfers();
      run_op(ACT_WRITE, 8'hA5, 8'h00, 1'b0, 1'b0, 1'b1);
      run_op(ACT_READ, 8'h00, 8'h3C, 1'b0, 1'b1, 1'b0);
   endtask

   // zero durations: forced to one tick or the phase is skipped
   task automatic test_zero_timing();
      set_all_timing('0);
      load_timing();
      run_op(ACT_RESET, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
      run_op(ACT_WRITE, 8'h5A, 8'h00, 1'b0, 1'b0, 1'b1);
      run_op(ACT_READ, 8'h00, 8'h96, 1'b0, 1'b1, 1'b1);
   endtask

   // operations one after another with no gaps on either side
   task automatic test_back_to_back();
      next_timing = '{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd2, 10'd1, 10'd2};
      load_timing();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      for (int i = 0; i < 2; i++)
         run_op(2'($urandom_range(3, 1)), 8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b1);
      wait_all_results();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // result side holds off long enough that the block stalls its tick input
   task automatic test_rx_pressure();
      @(negedge clock);
      stall_len = 400;
      stall_req_id++;
      for (int i = 0; i < 16; i++) send_tick(ACT_TICK, 8'($urandom), 1'($urandom));
      run_op(ACT_RESET, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1);
   endtask

   // random operations, idle runs and refused commands over two timing settings
   task automatic test_random_ops();
      int start_count;
      for (int setting = 0; setting < 2; setting++) begin
         case (setting)
            0: set_random_timing(3);
            default: set_random_timing(1);
         endcase
         load_timing();
         start_count = ticks_sent;
         while (ticks_sent - start_count < 30) begin
            if ($urandom_range(99) < 15) begin
               repeat ($urandom_range(5, 1))
                  send_tick(ACT_TICK, 8'($urandom), 1'($urandom));
            end else begin
               run_op(2'($urandom_range(3, 1)), 8'($urandom), 8'h00, 1'b1,
                      $urandom_range(99) < 40, $urandom_range(99) < 30);
            end
         end
      end
   endtask

   initial begin
      bus_phase    = PH_IDLE;
      slot_cnt     = '0;
      shift_bits   = '0;
      bits_done    = '0;
      saw_presence = 1'b0;
      last_rx      = '0;
      timing       = DEFAULT_TIMING;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_presence_short();
      test_byte_transfers();
      test_zero_timing();
      test_back_to_back();
      test_rx_pressure();
      test_random_ops();
      wait_all_results();

      $display("run covered %0d tick beats, %0d finished bus operations, %0d refused commands",
               ticks_sent, ops_finished, refusals_seen);
      $display("timing: short, all zero, shortest and small random settings");
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("timeout with %0d results outstanding", bus_results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> sim.f
src/owm_pkg.sv
src/one_wire_bus_master_top.sv
bench/testbench.sv
